@@ hdl/kmer_simhash_signature_core_assert.svh @@
// ---------------------------------------------------------------------------
// kmer_simhash_signature_core assertion macros
// Concurrent check wrappers used by kss_ctrl; compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef KMER_SIMHASH_SIGNATURE_CORE_ASSERT_SVH
`define KMER_SIMHASH_SIGNATURE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define KSS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: check failed");
// Consequent must hold in the cycle after the antecedent.
`define KSS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define KSS_ASSERT(lbl, clk, rst, prop)
`define KSS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ hdl/kss_pkg.sv @@
// ---------------------------------------------------------------------------
// kss_pkg
// Shared constants, command/status types and helpers for the k-mer SimHash.
// ---------------------------------------------------------------------------
`default_nettype none

package kss_pkg;

  localparam int SYM_W    = 8;
  localparam int SIG_W    = 32;
  localparam int KCOUNT_W = 16;

  localparam int KMER_LEN_DEFAULT    = 3;
  localparam int MAX_SEQ_LEN_DEFAULT = 65535;

  localparam logic [SIG_W-1:0] HASH_BASIS = 32'h811C_9DC5;
  localparam logic [SIG_W-1:0] HASH_MULT  = 32'h0100_0193;

  // Controller to datapath
  typedef struct packed {
    logic take;       // byte accepted: shift in or flag overflow, reload basis
    logic hash_step;  // one FNV-1a round on the oldest byte, rotate window
    logic vote;       // add the finished hash to the vote counters
    logic emit;       // load result register, clear sequence state
  } kss_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic can_hash;   // next accepted byte completes a window within range
    logic slot_free;  // result register can take a new transaction
  } kss_status_t;

  function automatic logic [SIG_W-1:0] sext_byte(input logic [SYM_W-1:0] b);
    sext_byte = {{(SIG_W-SYM_W){b[SYM_W-1]}}, b};
  endfunction

endpackage

`default_nettype wire

@@ hdl/kss_ctrl.sv @@
// ---------------------------------------------------------------------------
// kss_ctrl
// Sequencer: accepts bytes, steps the shared hash round, votes and emits.
// ---------------------------------------------------------------------------
`default_nettype none
`include "kmer_simhash_signature_core_assert.svh"

module kss_ctrl #(
  parameter int KMER_LEN = kss_pkg::KMER_LEN_DEFAULT
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                item_valid,
  input  wire                last,
  input  wire kss_pkg::kss_status_t status,
  output kss_pkg::kss_cmd_t  cmd,
  output logic               busy
);
  import kss_pkg::*;

  localparam int STEP_W = $clog2(KMER_LEN + 1);
  localparam logic [STEP_W-1:0] STEP_END = STEP_W'(KMER_LEN - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_VOTE,
    S_EMIT
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic              last_q;

  always_comb begin
    cmd           = '0;
    cmd.take      = (state == S_IDLE) && item_valid;
    cmd.hash_step = (state == S_HASH);
    cmd.vote      = (state == S_VOTE);
    cmd.emit      = (state == S_EMIT) && status.slot_free;
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      step   <= '0;
      last_q <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            last_q <= last;
            step   <= '0;
            if (status.can_hash) begin
              state <= S_HASH;
            end else if (last) begin
              state <= S_EMIT;
            end
          end
        end
        S_HASH: begin
          if (step == STEP_END) begin
            state <= S_VOTE;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        S_VOTE: begin
          state <= last_q ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (status.slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `KSS_ASSERT(a_step_range, clk, rst, (state != S_HASH) || (step <= STEP_END))
  `KSS_ASSERT_NEXT(a_take_to_hash, clk, rst, cmd.take && status.can_hash,
                   state == S_HASH && step == '0)
  `KSS_ASSERT_NEXT(a_hash_to_vote, clk, rst, state == S_HASH && step == STEP_END,
                   state == S_VOTE)

endmodule

`default_nettype wire

@@ hdl/kss_datapath.sv @@
// ---------------------------------------------------------------------------
// kss_datapath
// Byte window, shared FNV-1a round, vote counters and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module kss_datapath #(
  parameter int KMER_LEN    = kss_pkg::KMER_LEN_DEFAULT,
  parameter int MAX_SEQ_LEN = kss_pkg::MAX_SEQ_LEN_DEFAULT
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire kss_pkg::kss_cmd_t            cmd,
  output kss_pkg::kss_status_t              status,
  input  wire  [kss_pkg::SYM_W-1:0]         symbol,
  output logic                              result_valid,
  input  wire                               result_stall,
  output logic [kss_pkg::SIG_W-1:0]         signature,
  output logic [kss_pkg::KCOUNT_W-1:0]      kmer_count,
  output logic                              truncated
);
  import kss_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SEQ_LEN + 1);
  localparam int VOTE_W = CNT_W + 1;
  localparam int SAT_W  = (CNT_W > KCOUNT_W) ? CNT_W : KCOUNT_W;

  logic [SYM_W-1:0]  window [KMER_LEN];
  logic [SIG_W-1:0]  hash;
  logic [SIG_W-1:0]  hash_next;
  logic [CNT_W-1:0]  bytes_seen;
  logic              overflow;
  logic [VOTE_W-1:0] votes [SIG_W];
  logic              in_range;
  logic [SAT_W-1:0]  windows;
  logic [SIG_W-1:0]  signature_next;
  logic [KCOUNT_W-1:0] kmer_count_next;

  assign in_range = (bytes_seen < CNT_W'(MAX_SEQ_LEN));

  always_comb begin
    status.can_hash  = in_range && (bytes_seen >= CNT_W'(KMER_LEN - 1));
    status.slot_free = !result_valid || !result_stall;
  end

  // One FNV-1a round on the byte at the window head; the oldest byte leads
  assign hash_next = (hash ^ sext_byte(window[0])) * HASH_MULT;

  always_ff @(posedge clk) begin
    if (cmd.take && in_range) begin
      for (int i = 0; i < KMER_LEN - 1; i++) begin
        window[i] <= window[i+1];
      end
      window[KMER_LEN-1] <= symbol;
    end else if (cmd.hash_step) begin
      // rotate: after KMER_LEN rounds the window is back in order
      for (int i = 0; i < KMER_LEN - 1; i++) begin
        window[i] <= window[i+1];
      end
      window[KMER_LEN-1] <= window[0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      hash <= HASH_BASIS;
    end else if (cmd.hash_step) begin
      hash <= hash_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      overflow   <= 1'b0;
      for (int j = 0; j < SIG_W; j++) begin
        votes[j] <= '0;
      end
    end else if (cmd.emit) begin
      bytes_seen <= '0;
      overflow   <= 1'b0;
      for (int j = 0; j < SIG_W; j++) begin
        votes[j] <= '0;
      end
    end else begin
      if (cmd.take) begin
        if (in_range) begin
          bytes_seen <= bytes_seen + CNT_W'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
      if (cmd.vote) begin
        for (int j = 0; j < SIG_W; j++) begin
          votes[j] <= hash[j] ? votes[j] + VOTE_W'(1) : votes[j] - VOTE_W'(1);
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < SIG_W; j++) begin
      signature_next[SIG_W-1-j] = !votes[j][VOTE_W-1] && (votes[j] != '0);
    end
    if (bytes_seen >= CNT_W'(KMER_LEN)) begin
      windows = SAT_W'(bytes_seen - CNT_W'(KMER_LEN - 1));
    end else begin
      windows = '0;
    end
    if (windows > SAT_W'({KCOUNT_W{1'b1}})) begin
      kmer_count_next = {KCOUNT_W{1'b1}};
    end else begin
      kmer_count_next = windows[KCOUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      signature  <= signature_next;
      kmer_count <= kmer_count_next;
      truncated  <= overflow;
    end
  end

endmodule

`default_nettype wire

@@ hdl/kmer_simhash_signature_core.sv @@
// ---------------------------------------------------------------------------
// kmer_simhash_signature_core
// SimHash signature of a byte sequence over FNV-1a hashed k-mer windows.
// ---------------------------------------------------------------------------
// Bytes arrive one per transaction on the item channel, the final byte
// flagged by last. Every window of KMER_LEN consecutive bytes is hashed
// with 32-bit FNV-1a (bytes sign-extended, oldest first) and each hash bit
// j votes +1 or -1 on counter j. After the final byte one result
// transaction carries the signature (bit 31-j set when counter j is
// positive), the number of windows (saturating at 65535) and a truncation
// flag; the sequence state is then cleared. Bytes beyond MAX_SEQ_LEN are
// dropped and only raise truncated.
// A byte that completes a window holds the block for its accept, one
// round of the shared 32x32 FNV multiplier per window byte and one vote
// update; a byte that completes no window leaves the item channel free.
// A final byte then loads the result register in the emit state, waiting
// while a previous result is still held by result_stall. The result
// register decouples the channels: bytes flow on while a result waits.
// ---------------------------------------------------------------------------
`default_nettype none

module kmer_simhash_signature_core #(
  parameter int KMER_LEN    = kss_pkg::KMER_LEN_DEFAULT,
  parameter int MAX_SEQ_LEN = kss_pkg::MAX_SEQ_LEN_DEFAULT
) (
  input  wire                           clk,
  input  wire                           rst,
  // item channel
  input  wire                           item_valid,
  output logic                          item_stall,
  input  wire  [kss_pkg::SYM_W-1:0]     symbol,
  input  wire                           last,
  // result channel
  output logic                          result_valid,
  input  wire                           result_stall,
  output logic [kss_pkg::SIG_W-1:0]     signature,
  output logic [kss_pkg::KCOUNT_W-1:0]  kmer_count,
  output logic                          truncated
);
  import kss_pkg::*;

  kss_cmd_t    cmd;
  kss_status_t status;
  logic        busy;

  // Hold the item channel while a byte is being hashed or voted or a result loaded
  assign item_stall = busy;

  kss_ctrl #(
    .KMER_LEN (KMER_LEN)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .last       (last),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy)
  );

  kss_datapath #(
    .KMER_LEN    (KMER_LEN),
    .MAX_SEQ_LEN (MAX_SEQ_LEN)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .symbol       (symbol),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .signature    (signature),
    .kmer_count   (kmer_count),
    .truncated    (truncated)
  );

endmodule

`default_nettype wire
